// ===== sv/bsm_pkg.sv =====
`default_nettype none
package bsm_pkg;

	// Port widths are fixed; OPERAND_WIDTH selects how many low operand bits take part.
	localparam int DATA_WIDTH        = 32;
	localparam int PRODUCT_WIDTH     = 64;
	localparam int OPERAND_WIDTH_DEF = 32;

	// Booth steps evaluated between two pipeline registers.
	localparam int STEPS_PER_STAGE   = 2;

	typedef enum logic [1:0] {
		BOOTH_NOP_LO = 2'b00,
		BOOTH_ADD    = 2'b01,
		BOOTH_SUB    = 2'b10,
		BOOTH_NOP_HI = 2'b11
	} booth_op_t;

endpackage
`default_nettype wire

// ===== sv/booth_signed_multiplier.sv =====
`default_nettype none
// Pipelined radix-2 Booth multiplier: takes a pair of signed operands on any cycle with start
// high (busy is held low, so every start is a transfer) and returns the full signed product,
// sign-extended to 64 bits, on product with done high for exactly one cycle. The receiver
// cannot stall the pipeline, so one item per cycle is sustained. Each register stage holds
// two dependent Booth add/subtract-and-shift steps (the last stage fewer when OPERAND_WIDTH
// is odd) on an (OPERAND_WIDTH+1)-bit accumulator. Only the low OPERAND_WIDTH bits of each
// operand are used, read as two's complement.
module booth_signed_multiplier #(
	parameter int OPERAND_WIDTH = bsm_pkg::OPERAND_WIDTH_DEF
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire                                       start,
	output logic                                      busy,
	input  wire  signed [bsm_pkg::DATA_WIDTH-1:0]     multiplicand,
	input  wire  signed [bsm_pkg::DATA_WIDTH-1:0]     multiplier,
	output logic                                      done,
	output logic signed [bsm_pkg::PRODUCT_WIDTH-1:0]  product
);

	localparam int W   = OPERAND_WIDTH;
	localparam int SPS = bsm_pkg::STEPS_PER_STAGE;
	localparam int NS  = (W + SPS - 1) / SPS;
	localparam int PW  = bsm_pkg::PRODUCT_WIDTH;

	// per-stage pipeline registers
	logic                valid_s [NS];
	logic signed [W:0]   acc_s   [NS];
	logic signed [W:0]   mc_s    [NS];
	logic        [W-1:0] q_s     [NS];
	logic                qp_s    [NS];

	// next-state values for each stage
	logic signed [W:0]   acc_nxt [NS];
	logic signed [W:0]   mc_in   [NS];
	logic        [W-1:0] q_nxt   [NS];
	logic                qp_nxt  [NS];
	logic                v_in    [NS];

	logic signed [2*W-1:0] prod_wide;

	assign busy = 1'b0;

	always_comb begin
		for (int g = 0; g < NS; g++) begin
			if (g == 0) begin
				v_in[g]    = start && !busy;
				mc_in[g]   = {multiplicand[W-1], multiplicand[W-1:0]};
				acc_nxt[g] = '0;
				q_nxt[g]   = multiplier[W-1:0];
				qp_nxt[g]  = 1'b0;
			end else begin
				v_in[g]    = valid_s[g-1];
				mc_in[g]   = mc_s[g-1];
				acc_nxt[g] = acc_s[g-1];
				q_nxt[g]   = q_s[g-1];
				qp_nxt[g]  = qp_s[g-1];
			end
			for (int k = 0; k < SPS; k++) begin
				// last stage may have fewer steps when the width is odd
				if (g * SPS + k < W) begin
					unique case (bsm_pkg::booth_op_t'({q_nxt[g][0], qp_nxt[g]}))
						bsm_pkg::BOOTH_SUB: acc_nxt[g] = acc_nxt[g] - mc_in[g];
						bsm_pkg::BOOTH_ADD: acc_nxt[g] = acc_nxt[g] + mc_in[g];
						default: ;
					endcase
					qp_nxt[g]  = q_nxt[g][0];
					q_nxt[g]   = {acc_nxt[g][0], q_nxt[g][W-1:1]};
					acc_nxt[g] = acc_nxt[g] >>> 1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NS; g++) begin
				valid_s[g] <= 1'b0;
			end
		end else begin
			for (int g = 0; g < NS; g++) begin
				valid_s[g] <= v_in[g];
			end
		end
	end

	// payload only moves with a valid item
	always_ff @(posedge clk) begin
		for (int g = 0; g < NS; g++) begin
			if (v_in[g]) begin
				acc_s[g] <= acc_nxt[g];
				mc_s[g]  <= mc_in[g];
				q_s[g]   <= q_nxt[g];
				qp_s[g]  <= qp_nxt[g];
			end
		end
	end

	// exact product fits in 2W bits; the accumulator's top bit is redundant by now
	assign prod_wide = {acc_s[NS-1][W-1:0], q_s[NS-1]};
	assign product   = PW'(prod_wide);
	assign done      = valid_s[NS-1];

`ifndef SYNTHESIS
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, NS))
		else $error("done without a start transfer NS cycles earlier");

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##NS done)
		else $error("start transfer did not produce done");

	a_zero_multiplier: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(multiplier[W-1:0] == '0, NS) |-> product == '0)
		else $error("zero multiplier gave nonzero product");

	a_zero_multiplicand: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(multiplicand[W-1:0] == '0, NS) |-> product == '0)
		else $error("zero multiplicand gave nonzero product");
`endif

endmodule
`default_nettype wire

// ===== tb/booth_signed_multiplier_tb.sv =====
`default_nettype none
module booth_signed_multiplier_tb;

	localparam int OP_W        = bsm_pkg::OPERAND_WIDTH_DEF;
	localparam int PIPE_LAT    = (OP_W + 1) / 2;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DW          = bsm_pkg::DATA_WIDTH;
	localparam int PW          = bsm_pkg::PRODUCT_WIDTH;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic signed [DW-1:0]   multiplicand;
	logic signed [DW-1:0]   multiplier;
	logic                   done;
	logic signed [PW-1:0]   product;

	logic [PW-1:0]            product_q[$];
	int unsigned              err_cnt   = 0;
	int unsigned              cycle_cnt = 0;
	bit                       idle_en   = 1'b1;

	booth_signed_multiplier #(
		.OPERAND_WIDTH(OP_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.multiplicand(multiplicand),
		.multiplier  (multiplier),
		.done        (done),
		.product     (product)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Booth recoding over the low OP_W bits; A:Q:Q_prev shift as one register
	function automatic logic [PW-1:0] booth_product(
		input logic [DW-1:0] a,
		input logic [DW-1:0] b
	);
		logic [DW-1:0]       wmask;
		logic [PW-1:0]       mcand;
		logic [PW-1:0]       acc;
		logic [DW-1:0]       q;
		logic                q_prev;
		logic                q0;
		logic                acc_lsb;
		bsm_pkg::booth_op_t  op;
		wmask  = (OP_W >= DW) ? '1 : ((32'd1 << OP_W) - 32'd1);
		mcand  = {32'd0, a & wmask};
		if (a[OP_W-1])
			mcand = mcand | ~{32'd0, wmask};
		q      = b & wmask;
		acc    = '0;
		q_prev = 1'b0;
		for (int i = 0; i < OP_W; i++) begin
			q0 = q[0];
			op = bsm_pkg::booth_op_t'({q0, q_prev});
			if (op == bsm_pkg::BOOTH_SUB)
				acc = acc - mcand;
			else if (op == bsm_pkg::BOOTH_ADD)
				acc = acc + mcand;
			acc_lsb = acc[0];
			acc     = {acc[PW-1], acc[PW-1:1]};
			q       = (q >> 1) | ({31'd0, acc_lsb} << (OP_W - 1));
			q_prev  = q0;
		end
		return (acc << OP_W) | {32'd0, q & wmask};
	endfunction

	// Operand mix: extremes, small magnitudes, single bits and bit patterns
	function automatic logic [DW-1:0] pick_operand();
		logic [DW-1:0]         v;
		int unsigned           k;
		k = $urandom_range(0, 31);
		case ($urandom_range(0, 11))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			2: v = $urandom_range(0, 15);
			3: v = -$urandom_range(0, 15);
			4: v = 32'd1 << k;
			5: v = ~(32'd1 << k);
			6: v = $urandom() & $urandom();
			7: v = $urandom() | $urandom();
			8: v = {16{2'b01}} ^ (32'd1 << k);
			default: v = $urandom();
		endcase
		return v;
	endfunction

	task automatic idle_cycles(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_operands(input logic [DW-1:0] a, input logic [DW-1:0] b);
		if (idle_en && $urandom_range(0, 5) == 0)
			idle_cycles($urandom_range(1, 17));
		start        <= 1'b1;
		multiplicand <= a;
		multiplier   <= b;
		do
			@(posedge clk);
		while (busy);
		product_q.push_back(booth_product(a, b));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (product_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (product_q.size() == 0) begin
				err_cnt++;
				$display("%0t product with none pending: expected none actual %h", $time,
					product);
			end else begin
				if (product !== product_q[0]) begin
					err_cnt++;
					$display("%0t product mismatch: expected %h actual %h", $time,
						product_q[0], product);
				end
				void'(product_q.pop_front());
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("** booth_signed_multiplier: FAILED **");
		$finish;
	end

	task automatic test_corners();
		logic [DW-1:0] vals[6];
		vals = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 32'h5555_5555};
		// most negative squared, extremes against each other
		send_operands(32'h8000_0000, 32'h8000_0000);
		send_operands(32'h7fff_ffff, 32'h7fff_ffff);
		send_operands(32'h8000_0000, 32'h7fff_ffff);
		send_operands(32'h7fff_ffff, 32'h8000_0000);
		send_operands(32'h8000_0000, 32'hffff_ffff);
		send_operands(32'hffff_ffff, 32'hffff_ffff);
		// alternating multiplier bits force an add or subtract on every step (but the first for aaaa_aaaa)
		send_operands(32'h1234_5678, 32'h5555_5555);
		send_operands(32'h8765_4321, 32'haaaa_aaaa);
		send_operands(32'hffff_ffff, 32'h0000_0000);
		send_operands(32'h0000_0000, 32'h8000_0000);
		for (int i = 0; i < 6; i++)
			send_operands(vals[i], vals[5 - i]);
		send_operands(32'h0000_0001, 32'h8000_0000);
		send_operands(32'hdead_beef, 32'h0000_0001);
		send_operands(32'hffff_0000, 32'h0000_ffff);
	endtask

	task automatic test_drain_pauses();
		for (int g = 0; g < 4; g++) begin
			for (int i = 0; i < 10; i++)
				send_operands(pick_operand(), pick_operand());
			wait_drained();
		end
	endtask

	task automatic test_random_ops();
		for (int i = 0; i < 400; i++)
			send_operands(pick_operand(), pick_operand());
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		for (int i = 0; i < 100; i++)
			send_operands($urandom(), pick_operand());
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		multiplicand = '0;
		multiplier   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_drain_pauses();
		test_random_ops();
		test_back_to_back();

		wait_drained();
		repeat (2 * PIPE_LAT + 8) @(posedge clk);
		if (err_cnt == 0)
			$display("** booth_signed_multiplier: PASSED **");
		else
			$display("** booth_signed_multiplier: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
sv/bsm_pkg.sv
sv/booth_signed_multiplier.sv
tb/booth_signed_multiplier_tb.sv
